// ----- sv/bsmg_pkg.sv -----
// Shared constants and types for the bounded set min-gap range unit.
// Used by bsmg_scan and bounded_set_min_gap_range_unit.
// Depends on nothing else.
package bsmg_pkg;

    // Store geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);

    // Field widths fixed by the item format.
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;
    localparam int OUT_W  = 80;

    // Store depth as a count value, and the capacity after reset.
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Status codes.
    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    // Neighbor search result handed from the scan unit to the control.
    typedef struct packed {
        logic                    done;
        logic                    have_below;
        logic                    have_above;
        logic signed [VAL_W-1:0] below;
        logic signed [VAL_W-1:0] above;
    } scan_res_t;

    // Control sequence of the top level.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_REPORT = 4'b1000
    } ctrl_state_t;

endpackage

// ----- sv/bsmg_scan.sv -----
// Value store and neighbor search: a DEPTH x 32 synchronous memory swept
// one entry per cycle to find the nearest held values below and above a key.
// Depends on bsmg_pkg.
module bsmg_scan
    import bsmg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] key,
    input  logic [CNT_W-1:0]        n,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [VAL_W-1:0]        wr_data,
    output scan_res_t               res
);

    logic [VAL_W-1:0]        mem [DEPTH];
    logic                    busy_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    rvalid_reg;
    logic [VAL_W-1:0]        rdata_reg;
    logic                    done_reg;
    logic                    have_below_reg;
    logic                    have_above_reg;
    logic signed [VAL_W-1:0] below_reg;
    logic signed [VAL_W-1:0] above_reg;

    logic                    issue;
    logic signed [VAL_W-1:0] s_val;
    logic                    take_below;
    logic                    take_above;

    // A read is issued each cycle until all held entries have been requested.
    assign issue = busy_reg && (idx_reg != n);

    // Compare the entry read in the previous cycle against the best so far.
    assign s_val      = rdata_reg;
    assign take_below = rvalid_reg && (s_val <= key) && (!have_below_reg || (s_val > below_reg));
    assign take_above = rvalid_reg && (s_val >= key) && (!have_above_reg || (s_val < above_reg));

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // Sweep control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            idx_reg        <= '0;
            rvalid_reg     <= 1'b0;
            done_reg       <= 1'b0;
            have_below_reg <= 1'b0;
            have_above_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            rvalid_reg <= issue;
            if (start)
            begin
                busy_reg       <= 1'b1;
                idx_reg        <= '0;
                have_below_reg <= 1'b0;
                have_above_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (take_below)
                begin
                    have_below_reg <= 1'b1;
                end
                if (take_above)
                begin
                    have_above_reg <= 1'b1;
                end
                if (busy_reg && !issue && !rvalid_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Best neighbor values.
    always_ff @(posedge clk)
    begin
        if (take_below)
        begin
            below_reg <= s_val;
        end
        if (take_above)
        begin
            above_reg <= s_val;
        end
    end

    assign res.done       = done_reg;
    assign res.have_below = have_below_reg;
    assign res.have_above = have_above_reg;
    assign res.below      = below_reg;
    assign res.above      = above_reg;

endmodule

// ----- sv/bounded_set_min_gap_range_unit.sv -----
// Top level of the bounded set min-gap range unit: handshakes, control
// sequence, running min/max/gap state and the output register.
// Depends on bsmg_pkg and bsmg_scan.
//
//  Channel   Ports                                   Moves
//  input     s_axis_tvalid/tready/tdata[31:0]        one value per beat
//  output    m_axis_tvalid/tready/tdata[79:0]        one result per beat
//  config    cfg_we/cfg_wdata[6:0]                   capacity register
//
// A stored value passes through the scan, update and report steps: the store
// memory is swept over the values already held, one entry per cycle, and the
// compare works on each entry in the cycle after it is read. A rejected value
// goes straight from the idle step to the report step. The input is ready again
// once the unit is idle again; a stalled output holds it in its report step.
// Reset clears the set, the running extremes and the gap; capacity returns
// to 64. The next value is taken while a result still waits on the output.
module bounded_set_min_gap_range_unit
    import bsmg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VAL_W-1:0]   s_axis_tdata,   // value[31:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // status[0], count[7:1], span_valid[8],
                                               // shortest_span[40:9], longest_span[72:41],
                                               // zero[79:73]
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata
);

    ctrl_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] least_reg;
    logic signed [VAL_W-1:0] greatest_reg;
    logic [VAL_W-1:0]        gap_reg;
    logic                    status_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    logic                    in_beat;
    logic [CNT_W-1:0]        limit;
    logic                    full;
    logic                    start;
    logic                    out_free;
    scan_res_t               scan_res;
    logic [VAL_W-1:0]        d_below;
    logic [VAL_W-1:0]        d_above;
    logic [VAL_W-1:0]        gap_1;
    logic [VAL_W-1:0]        gap_next;
    logic                    span_ok;
    logic [VAL_W-1:0]        shortest;
    logic [VAL_W-1:0]        longest;
    logic                    wr_en;

    // Input handshake and admission check.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign limit         = (cap_reg > DEPTH_CNT) ? DEPTH_CNT : cap_reg;
    assign full          = (count_reg >= limit);
    assign start         = in_beat && !full;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign wr_en         = (state_reg == ST_UPDATE);

    bsmg_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .key     (value_reg),
        .n       (count_reg),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (value_reg),
        .res     (scan_res)
    );

    // Gap update from the neighbors found by the sweep.
    always_comb
    begin
        d_below = value_reg - scan_res.below;
        d_above = scan_res.above - value_reg;
        gap_1   = (scan_res.have_below && (d_below < gap_reg)) ? d_below : gap_reg;
        gap_next = (scan_res.have_above && (d_above < gap_1)) ? d_above : gap_1;
    end

    // Result fields from the settled state.
    always_comb
    begin
        span_ok  = (count_reg >= CNT_W'(2));
        shortest = span_ok ? gap_reg : '0;
        longest  = span_ok ? VAL_W'(greatest_reg - least_reg) : '0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = full ? ST_REPORT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and set state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            least_reg     <= '0;
            greatest_reg  <= '0;
            gap_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (state_reg == ST_UPDATE)
            begin
                gap_reg   <= gap_next;
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    least_reg    <= value_reg;
                    greatest_reg <= value_reg;
                end
                else
                begin
                    if (value_reg < least_reg)
                    begin
                        least_reg <= value_reg;
                    end
                    if (value_reg > greatest_reg)
                    begin
                        greatest_reg <= value_reg;
                    end
                end
            end
            if ((state_reg == ST_REPORT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input value, status and output payload.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            value_reg  <= s_axis_tdata;
            status_reg <= full ? STATUS_FULL : STATUS_STORED;
        end
        if ((state_reg == ST_REPORT) && out_free)
        begin
            out_data_reg <= {7'b0, longest, shortest, span_ok, count_reg, status_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- dv/tb_bounded_set_min_gap_range_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bounded_set_min_gap_range_unit: offers values on the
// input stream, predicts each result and compares it with the output stream.
// Depends on bsmg_pkg and the unit under test.
module tb_bounded_set_min_gap_range_unit;
    import bsmg_pkg::*;

    // One expected result beat, fields as they leave the unit.
    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] count;
        logic             span_valid;
        logic [VAL_W-1:0] shortest_span;
        logic [VAL_W-1:0] longest_span;
    } span_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [VAL_W-1:0]   s_axis_tdata = '0;     // value[31:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;          // status[0], count[7:1], span_valid[8],
                                               // shortest_span[40:9], longest_span[72:41]
    logic               cfg_we = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata = '0;

    // Values waiting to be offered and results waiting to arrive.
    logic [VAL_W-1:0]   pending_values[$];
    span_result_t       expected_results[$];

    // Predicted contents of the set and the capacity register.
    logic signed [VAL_W-1:0] set_vals[DEPTH];
    int                      set_count = 0;
    logic signed [VAL_W-1:0] set_least = '0;
    logic signed [VAL_W-1:0] set_greatest = '0;
    logic [VAL_W-1:0]        set_gap = '1;
    logic [CNT_W-1:0]        set_cap = CAP_RESET;

    // Idle control of both sides.
    int   in_idle = 0;
    logic in_calm = 1'b0;
    int   out_idle = 0;
    int   out_draw;
    logic out_calm = 1'b0;

    // Run statistics.
    int error_count = 0;
    int values_stored = 0;
    int values_rejected = 0;
    int cap_writes = 0;

    bounded_set_min_gap_range_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Appends one value to the queue of values waiting to be offered.
    function automatic void offer_value(input logic [VAL_W-1:0] v);
        pending_values.insert(pending_values.size(), v);
    endfunction

    // Offers one value to the predicted set and returns the result it causes.
    function automatic span_result_t predict_insert(input logic signed [VAL_W-1:0] v);
        span_result_t            r;
        int                      limit;
        int                      i;
        logic                    have_lo;
        logic                    have_hi;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic [VAL_W-1:0]        d;
        limit = (int'(set_cap) > DEPTH) ? DEPTH : int'(set_cap);
        r = '0;
        if (set_count >= limit)
        begin
            r.status = STATUS_FULL;
            values_rejected++;
        end
        else
        begin
            r.status = STATUS_STORED;
            values_stored++;
            have_lo = 1'b0;
            have_hi = 1'b0;
            lo = '0;
            hi = '0;
            // Nearest held neighbors at or below and at or above the value.
            for (i = 0; i < set_count; i++)
            begin
                if (set_vals[i] <= v && (!have_lo || set_vals[i] > lo))
                begin
                    lo = set_vals[i];
                    have_lo = 1'b1;
                end
                if (set_vals[i] >= v && (!have_hi || set_vals[i] < hi))
                begin
                    hi = set_vals[i];
                    have_hi = 1'b1;
                end
            end
            // The true differences fit in 32 unsigned bits, so wrapping is exact.
            if (have_lo)
            begin
                d = v - lo;
                if (d < set_gap)
                    set_gap = d;
            end
            if (have_hi)
            begin
                d = hi - v;
                if (d < set_gap)
                    set_gap = d;
            end
            if (set_count == 0)
            begin
                set_least = v;
                set_greatest = v;
            end
            else
            begin
                if (v < set_least)
                    set_least = v;
                if (v > set_greatest)
                    set_greatest = v;
            end
            set_vals[set_count] = v;
            set_count++;
        end
        r.count = CNT_W'(set_count);
        if (set_count >= 2)
        begin
            r.span_valid = 1'b1;
            r.shortest_span = set_gap;
            r.longest_span = set_greatest - set_least;
        end
        return r;
    endfunction

    // Compares one output beat with the oldest expected result.
    function automatic void check_result(input logic [OUT_W-1:0] beat);
        span_result_t e;
        span_result_t a;
        a.status = beat[0];
        a.count = beat[7:1];
        a.span_valid = beat[8];
        a.shortest_span = beat[40:9];
        a.longest_span = beat[72:41];
        if (expected_results.size() == 0)
        begin
            $error("result beat with nothing expected: %h", beat);
            error_count++;
            return;
        end
        e = expected_results.pop_front();
        if (a.status !== e.status)
        begin
            $error("status mismatch: expected %0d, actual %0d", e.status, a.status);
            error_count++;
        end
        if (a.count !== e.count)
        begin
            $error("count mismatch: expected %0d, actual %0d", e.count, a.count);
            error_count++;
        end
        if (a.span_valid !== e.span_valid)
        begin
            $error("span_valid mismatch: expected %0d, actual %0d", e.span_valid, a.span_valid);
            error_count++;
        end
        if (a.shortest_span !== e.shortest_span)
        begin
            $error("shortest_span mismatch: expected %0d, actual %0d",
                   e.shortest_span, a.shortest_span);
            error_count++;
        end
        if (a.longest_span !== e.longest_span)
        begin
            $error("longest_span mismatch: expected %0d, actual %0d",
                   e.longest_span, a.longest_span);
            error_count++;
        end
    endfunction

    // Input driver: predicts each accepted beat and presents the next value after its gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            in_idle <= 0;
            in_calm <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.insert(expected_results.size(), predict_insert(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (in_idle > 0)
                begin
                    in_idle <= in_idle - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_values.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_values.pop_front();
                    in_idle <= in_calm ? 0 : int'($urandom_range(0, 13));
                    if ($urandom_range(0, 15) == 0)
                        in_calm <= ~in_calm;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted beat and stalls a random number of cycles after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_idle <= 0;
            out_calm <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            check_result(m_axis_tdata);
            out_draw = out_calm ? 0 : int'($urandom_range(0, 13));
            if ($urandom_range(0, 15) == 0)
                out_calm <= ~out_calm;
            out_idle <= out_draw;
            m_axis_tready <= (out_draw == 0);
        end
        else if (out_idle > 0)
        begin
            out_idle <= out_idle - 1;
            m_axis_tready <= (out_idle == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Waits until every offered value has been answered.
    task automatic wait_drained();
        while (pending_values.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the capacity register while the unit is idle.
    task automatic write_capacity(input logic [CNT_W-1:0] c);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        set_cap = c;
        cap_writes++;
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] inserted[$];
        int               i;
        int               phase;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Capacity zero rejects everything, extremes included.
        write_capacity(7'd0);
        offer_value(32'h8000_0000);
        offer_value(32'h7FFF_FFFF);
        offer_value(32'h0000_0000);
        wait_drained();

        // A single slot: the most negative value goes in, the next is refused.
        write_capacity(7'd1);
        offer_value(32'h8000_0000);
        offer_value(32'h1234_5678);
        wait_drained();

        // The most positive value gives the widest possible span, then zero splits it.
        write_capacity(7'd3);
        offer_value(32'h7FFF_FFFF);
        offer_value(32'h0000_0000);
        offer_value(32'hFFFF_FFFF);
        wait_drained();

        // Capacity below the count keeps the held values and refuses new ones.
        write_capacity(7'd2);
        offer_value(32'h0000_0001);
        wait_drained();

        // Capacity above the store depth saturates; fill the rest of the store.
        // Spread values first, then a tight cluster, then duplicates, so the gap
        // shrinks step by step instead of collapsing at once.
        write_capacity(7'd127);
        inserted.insert(inserted.size(), 32'h8000_0000);
        inserted.insert(inserted.size(), 32'h7FFF_FFFF);
        inserted.insert(inserted.size(), 32'h0000_0000);
        base = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom();
        for (i = 0; i < DEPTH - 3; i++)
        begin
            if (i < 30)
                v = $urandom();
            else if (i < 52 || $urandom_range(0, 1) == 0)
                v = base + $urandom_range(0, 4095) - 32'd2048;
            else
                v = inserted[$urandom_range(0, inserted.size() - 1)];
            inserted.insert(inserted.size(), v);
            offer_value(v);
        end
        // The store is now full at its depth.
        for (i = 0; i < 4; i++)
            offer_value($urandom());
        wait_drained();

        // A full set under a range of capacity settings: every value is refused.
        for (phase = 0; phase < 10; phase++)
        begin
            case (phase % 4)
                0: write_capacity(7'd0);
                1: write_capacity(7'd64);
                2: write_capacity(7'd127);
                default: write_capacity(CNT_W'($urandom_range(0, 127)));
            endcase
            for (i = 0; i < 43; i++)
            begin
                case ($urandom_range(0, 11))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = $urandom();
                endcase
                offer_value(v);
            end
            wait_drained();
        end

        // Let any stray beat surface before closing.
        repeat (80) @(posedge clk);
        $display("Run offered %0d values: %0d stored, %0d refused as full.",
                 values_stored + values_rejected, values_stored, values_rejected);
        $display("Capacity was written %0d times, from zero up to beyond the store depth.",
                 cap_writes);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
